/* hw/rtl/pfbu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbu_pkg: shared types and constants of the packed field bit unpacker
// Register map, mode codes and the structs passed between front and back.
// ----------------------------------------------------------------------------
package pfbu_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned WidthW    = 7;

  localparam logic [1:0] MODE_PACKED = 2'd0;
  localparam logic [1:0] MODE_RAW32  = 2'd1;
  localparam logic [1:0] MODE_RAW64  = 2'd2;

  localparam logic [1:0] REG_FIELD_MODE = 2'd0;
  localparam logic [1:0] REG_BIT_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MIN_VALUE  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [1:0]        field_mode;
    logic [WidthW-1:0] width;       // effective value width, 1..64
    logic [ValueW-1:0] min_value;
  } cfg_t;

  typedef struct packed {
    logic busy;    // part of a byte still held in the back end
  } back_status_t;

endpackage

/* hw/rtl/packed_field_bit_unpacker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_field_bit_unpacker_top: LSB-first packed bit field unpacker
// Streams bytes in, streams decoded 64-bit values out; APB register port.
// ----------------------------------------------------------------------------
// A byte that completes no value is taken every cycle; one that completes one
// value, every cycle in which the output register is free or being read. A
// byte that completes n values holds the back end while the extraction stage
// cuts one value per cycle as the output register frees. Bytes wait in a
// QUEUE_DEPTH-entry queue; a value is held in the output register until taken.
module packed_field_bit_unpacker_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic        m_axis_tlast    // last value of the byte
);
  import pfbu_pkg::*;

  logic [1:0]        field_mode_q;
  logic [WidthW-1:0] bit_width_q;
  logic [ValueW-1:0] min_value_q;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  cfg_t              cfg;
  logic              push, pop, full, empty;
  item_t             in_item, head_item;
  back_status_t      back_status;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mode_q <= MODE_PACKED;
      bit_width_q  <= WidthW'(8);
      min_value_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FIELD_MODE: field_mode_q <= pwdata[1:0];
        REG_BIT_WIDTH:  bit_width_q  <= pwdata[WidthW-1:0];
        REG_MIN_VALUE:  min_value_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FIELD_MODE: prdata = {62'b0, field_mode_q};
      REG_BIT_WIDTH:  prdata = {57'b0, bit_width_q};
      REG_MIN_VALUE:  prdata = min_value_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.field_mode = field_mode_q;
    cfg.min_value  = min_value_q;
    priority if (field_mode_q == MODE_RAW32) begin
      cfg.width = WidthW'(32);
    end else if (field_mode_q != MODE_PACKED) begin
      cfg.width = WidthW'(64);
    end else if (bit_width_q == '0) begin
      cfg.width = WidthW'(1);
    end else if (bit_width_q > WidthW'(MaxWidth)) begin
      cfg.width = WidthW'(MaxWidth);
    end else begin
      cfg.width = bit_width_q;
    end
  end

  assign s_axis_tready     = !full;
  assign push              = s_axis_tvalid && s_axis_tready;
  assign in_item.data_byte = s_axis_tdata;
  assign in_item.restart   = s_axis_tuser;

  pfbu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (in_item),
    .pop_i       (pop),
    .head_item_o (head_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  pfbu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (!empty),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .status_o     (back_status)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue reports full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_busy_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.busy |-> m_axis_tvalid)
    else $error("byte in progress without a pending value");

  a_next_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("value of an unfinished byte not produced at once");

endmodule

/* hw/rtl/pfbu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbu_fifo: front queue of the unpacker
// Accepts bytes from the input stream and holds them for the back end.
// ----------------------------------------------------------------------------
module pfbu_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfbu_pkg::item_t push_item_i,
  input  logic            pop_i,
  output pfbu_pkg::item_t head_item_o,
  output logic            full_o,
  output logic            empty_o
);
  import pfbu_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o      = (count_q == FullCnt);
  assign empty_o     = (count_q == '0);
  assign head_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hw/rtl/pfbu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbu_back: bit extraction back end
// Appends queued bytes to the carried bits, cuts one value per cycle while the
// output register is free or being read, and holds it in the output register.
// ----------------------------------------------------------------------------
module pfbu_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfbu_pkg::cfg_t                 cfg_i,
  input  logic                           head_valid_i,
  input  pfbu_pkg::item_t                head_item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  output logic [pfbu_pkg::ValueW-1:0]    out_value_o,
  output logic                           out_last_o,
  input  logic                           out_ready_i,
  output pfbu_pkg::back_status_t         status_o
);
  import pfbu_pkg::*;

  logic [ValueW-1:0] acc_q, acc_d;
  logic [WidthW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [7:0]        p_q, p_d;
  logic [3:0]        k_q, k_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;

  logic              have, clr, fits, slot, step, last;
  logic [ValueW-1:0] acc_s, chunk, raw, absorbed;
  logic [WidthW-1:0] cnt_s, need, cnt_abs;
  logic [7:0]        p_s, mask8, rem;
  logic [3:0]        k_s, need4, kr;

  always_comb begin
    have     = busy_q | head_valid_i;
    clr      = !busy_q && (head_item_i.restart || (cnt_q >= cfg_i.width));
    acc_s    = clr ? '0 : acc_q;
    cnt_s    = clr ? '0 : cnt_q;
    p_s      = busy_q ? p_q : head_item_i.data_byte;
    k_s      = busy_q ? k_q : 4'd8;
    need     = cfg_i.width - cnt_s;
    fits     = ({3'b000, k_s} >= need);
    need4    = need[3:0];
    mask8    = 8'((9'd1 << need4) - 9'd1);
    chunk    = {56'b0, p_s & mask8} << cnt_s;
    raw      = acc_s | chunk;
    rem      = p_s >> need4;
    kr       = k_s - need4;
    last     = ({3'b000, kr} < cfg_i.width);
    absorbed = acc_s | ({56'b0, p_s} << cnt_s);
    cnt_abs  = cnt_s + {3'b000, k_s};
    slot     = !out_valid_q || out_ready_i;
    step     = have && (!fits || slot);
    pop_o    = step && !busy_q;
  end

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    p_d         = p_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    if (step) begin
      if (!fits) begin
        acc_d  = absorbed;
        cnt_d  = cnt_abs;
        busy_d = 1'b0;
      end else begin
        out_valid_d = 1'b1;
        out_value_d = (cfg_i.field_mode == MODE_PACKED) ? raw + cfg_i.min_value : raw;
        out_last_d  = last;
        if (last) begin
          acc_d  = {56'b0, rem};
          cnt_d  = {3'b000, kr};
          busy_d = 1'b0;
        end else begin
          acc_d  = '0;
          cnt_d  = '0;
          busy_d = 1'b1;
          p_d    = rem;
          k_d    = kr;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    k_q         <= k_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_last_o    = out_last_q;
  assign status_o.busy = busy_q;

endmodule
